FILE: rtl/nnsag_pkg.sv
`default_nettype none

package nnsag_pkg;

  // Fixed field widths
  localparam int unsigned SCALE_W = 20;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned ESZ_W   = 2;
  localparam int unsigned CRD_W   = 13;
  // Internal source coordinate width, covers MAX_DIM up to 16384
  localparam int unsigned SRC_W   = 14;
  localparam int unsigned OFF_W   = 29;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned WDATA_W = 20;

  localparam int unsigned MAX_DIM_DEF   = 8192;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_X_SCALE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_Y_SCALE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUT_COLS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_ROWS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_IN_STRIDE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUT_STRIDE = 3'd5;
  localparam logic [IDX_W-1:0] REG_ESZ_LOG2   = 3'd6;

  // Reset values
  localparam logic [SCALE_W-1:0] X_SCALE_RST    = 20'd65536;
  localparam logic [SCALE_W-1:0] Y_SCALE_RST    = 20'd65536;
  localparam logic [DIM_W-1:0]   OUT_COLS_RST   = 14'd1920;
  localparam logic [DIM_W-1:0]   OUT_ROWS_RST   = 14'd1080;
  localparam logic [PITCH_W-1:0] IN_STRIDE_RST  = 16'd1920;
  localparam logic [PITCH_W-1:0] OUT_STRIDE_RST = 16'd1920;
  localparam logic [ESZ_W-1:0]   ESZ_LOG2_RST   = 2'd0;
  localparam logic [ESZ_W-1:0]   ESZ_LOG2_MAX   = 2'd2;

  typedef struct packed {
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [DIM_W-1:0]   out_cols;
    logic [DIM_W-1:0]   out_rows;
    logic [PITCH_W-1:0] in_stride;
    logic [PITCH_W-1:0] out_stride;
    logic [ESZ_W-1:0]   element_size_log2;
  } cfg_t;

  // One walked position, handed from the walker to the address stage
  typedef struct packed {
    logic [CRD_W-1:0] dst_col;
    logic [CRD_W-1:0] dst_row;
    logic [SRC_W-1:0] src_col;
    logic [SRC_W-1:0] src_row;
    logic [OFF_W-1:0] dst_row_base;
    logic             end_of_line;
    logic             end_of_frame;
  } pos_t;

endpackage

`default_nettype wire

FILE: rtl/nnsag_in_if.sv
`default_nettype none

interface nnsag_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

FILE: rtl/nnsag_out_if.sv
`default_nettype none

interface nnsag_out_if;
  logic                         valid;
  logic                         ready;
  logic [nnsag_pkg::CRD_W-1:0]  dst_col;
  logic [nnsag_pkg::CRD_W-1:0]  dst_row;
  logic [nnsag_pkg::CRD_W-1:0]  src_col;
  logic [nnsag_pkg::CRD_W-1:0]  src_row;
  logic [nnsag_pkg::OFF_W-1:0]  src_offset;
  logic [nnsag_pkg::OFF_W-1:0]  dst_offset;
  logic                         end_of_line;
  logic                         end_of_frame;

  modport source (
    output valid, output dst_col, output dst_row, output src_col, output src_row,
    output src_offset, output dst_offset, output end_of_line, output end_of_frame,
    input ready
  );
  modport sink (
    input valid, input dst_col, input dst_row, input src_col, input src_row,
    input src_offset, input dst_offset, input end_of_line, input end_of_frame,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/nearest_neighbor_scale_address_gen.sv
// Each accepted word is registered in the walker's position register and then in
// the address stage's output register. Throughput: one word per cycle while the
// output is not stalled; the position counters and accumulators are updated by one
// add and compare each, so a word can follow every cycle. The source row offset
// multiply sits in the second (output) stage. Reset: asynchronous, active low; the
// control registers reset and the walk starts at the destination origin. No clearing pass.
`default_nettype none

module nearest_neighbor_scale_address_gen #(
  parameter int unsigned MAX_DIM   = nnsag_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = nnsag_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [nnsag_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [nnsag_pkg::WDATA_W-1:0] cfg_wdata_i,
  nnsag_in_if.sink                           in_i,
  nnsag_out_if.source                        out_o
);

  nnsag_pkg::cfg_t cfg;
  nnsag_pkg::pos_t pos;
  logic            pos_valid, pos_ready;

  nnsag_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nnsag_walker #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .restart_i   (in_i.restart),
    .pos_valid_o (pos_valid),
    .pos_ready_i (pos_ready),
    .pos_o       (pos)
  );

  nnsag_addr u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .pos_valid_i    (pos_valid),
    .pos_ready_o    (pos_ready),
    .pos_i          (pos),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .dst_col_o      (out_o.dst_col),
    .dst_row_o      (out_o.dst_row),
    .src_col_o      (out_o.src_col),
    .src_row_o      (out_o.src_row),
    .src_offset_o   (out_o.src_offset),
    .dst_offset_o   (out_o.dst_offset),
    .end_of_line_o  (out_o.end_of_line),
    .end_of_frame_o (out_o.end_of_frame)
  );

endmodule

`default_nettype wire

FILE: rtl/nnsag_cfg.sv
`default_nettype none

module nnsag_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [nnsag_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [nnsag_pkg::WDATA_W-1:0] cfg_wdata_i,
  output nnsag_pkg::cfg_t                    cfg_o
);

  nnsag_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_scale           <= nnsag_pkg::X_SCALE_RST;
      cfg_q.y_scale           <= nnsag_pkg::Y_SCALE_RST;
      cfg_q.out_cols          <= nnsag_pkg::OUT_COLS_RST;
      cfg_q.out_rows          <= nnsag_pkg::OUT_ROWS_RST;
      cfg_q.in_stride         <= nnsag_pkg::IN_STRIDE_RST;
      cfg_q.out_stride        <= nnsag_pkg::OUT_STRIDE_RST;
      cfg_q.element_size_log2 <= nnsag_pkg::ESZ_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nnsag_pkg::REG_X_SCALE: begin
          cfg_q.x_scale <= cfg_wdata_i[nnsag_pkg::SCALE_W-1:0];
        end
        nnsag_pkg::REG_Y_SCALE: begin
          cfg_q.y_scale <= cfg_wdata_i[nnsag_pkg::SCALE_W-1:0];
        end
        nnsag_pkg::REG_OUT_COLS: begin
          cfg_q.out_cols <= cfg_wdata_i[nnsag_pkg::DIM_W-1:0];
        end
        nnsag_pkg::REG_OUT_ROWS: begin
          cfg_q.out_rows <= cfg_wdata_i[nnsag_pkg::DIM_W-1:0];
        end
        nnsag_pkg::REG_IN_STRIDE: begin
          cfg_q.in_stride <= cfg_wdata_i[nnsag_pkg::PITCH_W-1:0];
        end
        nnsag_pkg::REG_OUT_STRIDE: begin
          cfg_q.out_stride <= cfg_wdata_i[nnsag_pkg::PITCH_W-1:0];
        end
        nnsag_pkg::REG_ESZ_LOG2: begin
          cfg_q.element_size_log2 <= cfg_wdata_i[nnsag_pkg::ESZ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/nnsag_walker.sv
`default_nettype none

module nnsag_walker #(
  parameter int unsigned MAX_DIM   = nnsag_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = nnsag_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  nnsag_pkg::cfg_t      cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            restart_i,
  output logic                 pos_valid_o,
  input  wire logic            pos_ready_i,
  output nnsag_pkg::pos_t      pos_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  // Wide enough for the saturation cap and for an unsaturated scale/2
  localparam int unsigned AccW = (DimW + FRAC_BITS > nnsag_pkg::SCALE_W) ?
                                 DimW + FRAC_BITS : nnsag_pkg::SCALE_W;
  localparam int unsigned CmpW = (DimW > nnsag_pkg::DIM_W) ? DimW : nnsag_pkg::DIM_W;
  localparam logic [AccW:0]   AccCap   = (AccW + 1)'(MAX_DIM) << FRAC_BITS;
  localparam logic [AccW-1:0] CoordMax = AccW'(MAX_DIM - 1);
  localparam logic [CmpW-1:0] DimMax   = CmpW'(MAX_DIM);
  localparam logic [CmpW-1:0] DimOne   = CmpW'(1);

  logic [nnsag_pkg::CRD_W-1:0] col_q, col_d, row_q, row_d, cur_col, cur_row;
  logic [AccW-1:0]             xacc_q, xacc_d, yacc_q, yacc_d, cur_xacc, cur_yacc;
  logic [AccW-1:0]             x_half, y_half, x_sum, y_sum, sc_raw, sr_raw;
  logic [nnsag_pkg::OFF_W-1:0] base_q, base_d, cur_base;
  logic [CmpW-1:0]             w_ext, h_ext, w_clamp, h_clamp;
  logic                        eol, eof, in_fire;
  nnsag_pkg::pos_t             pos_q, pos_d;
  logic                        pos_valid_q;

  function automatic logic [AccW-1:0] acc_add(input logic [AccW-1:0] acc,
                                              input logic [nnsag_pkg::SCALE_W-1:0] step);
    logic [AccW:0] s;
    s = {1'b0, acc} + (AccW + 1)'(step);
    acc_add = (s > AccCap) ? AccW'(AccCap) : s[AccW-1:0];
  endfunction

  function automatic logic [AccW-1:0] coord_of(input logic [AccW-1:0] acc);
    logic [AccW-1:0] c;
    c = acc >> FRAC_BITS;
    coord_of = (c > CoordMax) ? CoordMax : c;
  endfunction

  assign in_ready_o = !pos_valid_q || pos_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    x_half = AccW'(cfg_i.x_scale >> 1);
    y_half = AccW'(cfg_i.y_scale >> 1);

    // restart applies the origin before this word's position is emitted
    cur_col  = restart_i ? '0 : col_q;
    cur_row  = restart_i ? '0 : row_q;
    cur_xacc = restart_i ? x_half : xacc_q;
    cur_yacc = restart_i ? y_half : yacc_q;
    cur_base = restart_i ? '0 : base_q;

    w_ext   = CmpW'(cfg_i.out_cols);
    h_ext   = CmpW'(cfg_i.out_rows);
    w_clamp = (w_ext == '0) ? DimOne : ((w_ext > DimMax) ? DimMax : w_ext);
    h_clamp = (h_ext == '0) ? DimOne : ((h_ext > DimMax) ? DimMax : h_ext);

    eol = CmpW'(cur_col) >= (w_clamp - DimOne);
    eof = eol && (CmpW'(cur_row) >= (h_clamp - DimOne));

    sc_raw = coord_of(cur_xacc);
    sr_raw = coord_of(cur_yacc);
    x_sum  = acc_add(cur_xacc, cfg_i.x_scale);
    y_sum  = acc_add(cur_yacc, cfg_i.y_scale);

    pos_d.dst_col      = cur_col;
    pos_d.dst_row      = cur_row;
    pos_d.src_col      = nnsag_pkg::SRC_W'(sc_raw);
    pos_d.src_row      = nnsag_pkg::SRC_W'(sr_raw);
    pos_d.dst_row_base = cur_base;
    pos_d.end_of_line  = eol;
    pos_d.end_of_frame = eof;

    if (!eol) begin
      col_d  = cur_col + 1'b1;
      row_d  = cur_row;
      xacc_d = x_sum;
      yacc_d = cur_yacc;
      base_d = cur_base;
    end else if (eof) begin
      col_d  = '0;
      row_d  = '0;
      xacc_d = x_half;
      yacc_d = y_half;
      base_d = '0;
    end else begin
      col_d  = '0;
      row_d  = cur_row + 1'b1;
      xacc_d = x_half;
      yacc_d = y_sum;
      base_d = cur_base + nnsag_pkg::OFF_W'(cfg_i.out_stride);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      xacc_q      <= AccW'(nnsag_pkg::X_SCALE_RST >> 1);
      yacc_q      <= AccW'(nnsag_pkg::Y_SCALE_RST >> 1);
      base_q      <= '0;
      pos_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q  <= col_d;
        row_q  <= row_d;
        xacc_q <= xacc_d;
        yacc_q <= yacc_d;
        base_q <= base_d;
      end
      if (in_ready_o) begin
        pos_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= pos_d;
    end
  end

  assign pos_valid_o = pos_valid_q;
  assign pos_o       = pos_q;

endmodule

`default_nettype wire

FILE: rtl/nnsag_addr.sv
`default_nettype none

module nnsag_addr (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  nnsag_pkg::cfg_t                  cfg_i,
  input  wire logic                        pos_valid_i,
  output logic                             pos_ready_o,
  input  nnsag_pkg::pos_t                  pos_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [nnsag_pkg::CRD_W-1:0]      dst_col_o,
  output logic [nnsag_pkg::CRD_W-1:0]      dst_row_o,
  output logic [nnsag_pkg::CRD_W-1:0]      src_col_o,
  output logic [nnsag_pkg::CRD_W-1:0]      src_row_o,
  output logic [nnsag_pkg::OFF_W-1:0]      src_offset_o,
  output logic [nnsag_pkg::OFF_W-1:0]      dst_offset_o,
  output logic                             end_of_line_o,
  output logic                             end_of_frame_o
);

  localparam int unsigned ProdW = nnsag_pkg::SRC_W + nnsag_pkg::PITCH_W;

  logic [nnsag_pkg::ESZ_W-1:0] esz;
  logic [ProdW-1:0]            row_prod;
  logic [nnsag_pkg::OFF_W-1:0] src_off_d, dst_off_d;
  logic                        out_valid_q, pos_fire;

  logic [nnsag_pkg::CRD_W-1:0] dst_col_q, dst_row_q, src_col_q, src_row_q;
  logic [nnsag_pkg::OFF_W-1:0] src_off_q, dst_off_q;
  logic                        eol_q, eof_q;

  assign pos_ready_o = !out_valid_q || out_ready_i;
  assign pos_fire    = pos_valid_i && pos_ready_o;

  always_comb begin
    // size code 3 behaves as 4 bytes
    esz = (cfg_i.element_size_log2 > nnsag_pkg::ESZ_LOG2_MAX) ?
          nnsag_pkg::ESZ_LOG2_MAX : cfg_i.element_size_log2;
    row_prod  = ProdW'(pos_i.src_row) * ProdW'(cfg_i.in_stride);
    src_off_d = nnsag_pkg::OFF_W'(row_prod)
              + (nnsag_pkg::OFF_W'(pos_i.src_col) << esz);
    dst_off_d = pos_i.dst_row_base + (nnsag_pkg::OFF_W'(pos_i.dst_col) << esz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pos_ready_o) begin
      out_valid_q <= pos_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_fire) begin
      dst_col_q <= pos_i.dst_col;
      dst_row_q <= pos_i.dst_row;
      src_col_q <= nnsag_pkg::CRD_W'(pos_i.src_col);
      src_row_q <= nnsag_pkg::CRD_W'(pos_i.src_row);
      src_off_q <= src_off_d;
      dst_off_q <= dst_off_d;
      eol_q     <= pos_i.end_of_line;
      eof_q     <= pos_i.end_of_frame;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dst_col_o      = dst_col_q;
  assign dst_row_o      = dst_row_q;
  assign src_col_o      = src_col_q;
  assign src_row_o      = src_row_q;
  assign src_offset_o   = src_off_q;
  assign dst_offset_o   = dst_off_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;

endmodule

`default_nettype wire
